FILE: hw/rtl/mte_pkg.sv
// Shared types, constants and helpers for the escape-time evaluator.
package mte_pkg;

    localparam int COORD_W = 32;
    localparam int PROD_W = 64;
    localparam int COUNT_W = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam int DEFAULT_MAX_COLUMNS = 1024;
    localparam int DEFAULT_MAX_ROWS = 1024;
    localparam int DEFAULT_FRACTION_BITS = 26;

    localparam logic [CFG_IDX_W-1:0] REG_X_MIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Y_MIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_X_STEP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y_STEP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT = 3'd4;

    localparam logic signed [COORD_W-1:0] RESET_X_MIN = -32'sd134217728;
    localparam logic signed [COORD_W-1:0] RESET_Y_MIN = -32'sd67108864;
    localparam logic signed [COORD_W-1:0] RESET_X_STEP = 32'sd315060;
    localparam logic signed [COORD_W-1:0] RESET_Y_STEP = 32'sd280157;
    localparam logic [COUNT_W-1:0] RESET_ITER_LIMIT = 8'd255;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_MUL,
        ST_EVAL
    } mte_state_t;

    typedef struct packed {
        logic load;
        logic calc_c;
        logic mul;
        logic update;
        logic finish;
    } mte_cmd_t;

    typedef struct packed {
        logic escaped;
        logic limit_hit;
    } mte_status_t;

    // Clamp a wide signed value to the signed coordinate range.
    function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] hi;
        logic signed [PROD_W-1:0] lo;
        hi = PROD_W'({1'b0, {(COORD_W-1){1'b1}}});
        lo = -hi - PROD_W'(1);
        if (v > hi) begin
            sat_coord = hi[COORD_W-1:0];
        end else if (v < lo) begin
            sat_coord = lo[COORD_W-1:0];
        end else begin
            sat_coord = v[COORD_W-1:0];
        end
    endfunction

endpackage

FILE: hw/rtl/mte_ctrl.sv
// Sequencing state machine for the escape-time evaluator.
module mte_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  mte_pkg::mte_status_t status,
    output mte_pkg::mte_cmd_t    cmd,
    output logic                 busy
);

    mte_pkg::mte_state_t state_reg;
    mte_pkg::mte_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= mte_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        busy = 1'b1;
        case (state_reg)
            mte_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start) begin
                    cmd.load = 1'b1;
                    state_next = mte_pkg::ST_SETUP;
                end
            end
            mte_pkg::ST_SETUP:
            begin
                cmd.calc_c = 1'b1;
                state_next = mte_pkg::ST_MUL;
            end
            mte_pkg::ST_MUL:
            begin
                cmd.mul = 1'b1;
                state_next = mte_pkg::ST_EVAL;
            end
            mte_pkg::ST_EVAL:
            begin
                // The escape test and the limit are checked together, so no update
                // follows an escaped point.
                if (status.escaped || status.limit_hit) begin
                    cmd.finish = 1'b1;
                    state_next = mte_pkg::ST_IDLE;
                end else begin
                    cmd.update = 1'b1;
                    state_next = mte_pkg::ST_MUL;
                end
            end
            default:
            begin
                state_next = mte_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: hw/rtl/mte_datapath.sv
// Configuration registers, point mapping and z iteration datapath.
module mte_datapath #(
    parameter int MAX_COLUMNS = mte_pkg::DEFAULT_MAX_COLUMNS,
    parameter int MAX_ROWS = mte_pkg::DEFAULT_MAX_ROWS,
    parameter int FRACTION_BITS = mte_pkg::DEFAULT_FRACTION_BITS,
    localparam int COL_W = $clog2(MAX_COLUMNS),
    localparam int ROW_W = $clog2(MAX_ROWS)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    input  logic [mte_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mte_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic [COL_W-1:0]                  pixel_column,
    input  logic [ROW_W-1:0]                  pixel_row,
    input  mte_pkg::mte_cmd_t                 cmd,
    output mte_pkg::mte_status_t              status,
    output logic                              done,
    output logic [mte_pkg::COUNT_W-1:0]       escape_count,
    output logic                              inside_set
);

    localparam int CW = mte_pkg::COORD_W;
    localparam int PW = mte_pkg::PROD_W;
    localparam logic [PW-1:0] LIMIT4 = PW'(4) << (2 * FRACTION_BITS);

    logic signed [CW-1:0] x_min_reg;
    logic signed [CW-1:0] y_min_reg;
    logic signed [CW-1:0] x_step_reg;
    logic signed [CW-1:0] y_step_reg;
    logic [mte_pkg::COUNT_W-1:0] iter_limit_reg;

    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    logic signed [CW-1:0] cre_reg;
    logic signed [CW-1:0] cim_reg;
    logic signed [CW-1:0] re_reg;
    logic signed [CW-1:0] im_reg;
    logic signed [PW-1:0] rr_reg;
    logic signed [PW-1:0] ii_reg;
    logic signed [PW-1:0] ri_reg;
    logic [mte_pkg::COUNT_W-1:0] count_reg;

    logic done_reg;
    logic [mte_pkg::COUNT_W-1:0] escape_count_reg;
    logic inside_set_reg;

    logic signed [COL_W+CW:0] xprod;
    logic signed [ROW_W+CW:0] yprod;
    logic signed [PW-1:0] xsum;
    logic signed [PW-1:0] ysum;
    logic signed [PW-1:0] rr_next;
    logic signed [PW-1:0] ii_next;
    logic signed [PW-1:0] ri_next;
    logic [PW-1:0] mag2;
    logic signed [PW-1:0] diff;
    logic signed [PW-1:0] nr;
    logic signed [PW-1:0] ni;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            x_min_reg <= mte_pkg::RESET_X_MIN;
            y_min_reg <= mte_pkg::RESET_Y_MIN;
            x_step_reg <= mte_pkg::RESET_X_STEP;
            y_step_reg <= mte_pkg::RESET_Y_STEP;
            iter_limit_reg <= mte_pkg::RESET_ITER_LIMIT;
        end else if (cfg_valid) begin
            case (cfg_index)
                mte_pkg::REG_X_MIN: x_min_reg <= $signed(cfg_data);
                mte_pkg::REG_Y_MIN: y_min_reg <= $signed(cfg_data);
                mte_pkg::REG_X_STEP: x_step_reg <= $signed(cfg_data);
                mte_pkg::REG_Y_STEP: y_step_reg <= $signed(cfg_data);
                mte_pkg::REG_ITER_LIMIT: iter_limit_reg <= cfg_data[mte_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Point mapping: c = min + index * step, clamped.
    assign xprod = $signed({1'b0, col_reg}) * x_step_reg;
    assign yprod = $signed({1'b0, row_reg}) * y_step_reg;
    assign xsum = PW'(xprod) + PW'(x_min_reg);
    assign ysum = PW'(yprod) + PW'(y_min_reg);

    assign rr_next = PW'(re_reg) * PW'(re_reg);
    assign ii_next = PW'(im_reg) * PW'(im_reg);
    assign ri_next = PW'(re_reg) * PW'(im_reg);

    assign mag2 = $unsigned(rr_reg) + $unsigned(ii_reg);
    assign diff = rr_reg - ii_reg;
    // Doubling re*im is folded into a shift one place shorter.
    assign nr = (diff >>> FRACTION_BITS) + PW'(cre_reg);
    assign ni = (ri_reg >>> (FRACTION_BITS - 1)) + PW'(cim_reg);

    assign status.escaped = (mag2 >= LIMIT4);
    assign status.limit_hit = (count_reg >= iter_limit_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load) begin
            col_reg <= pixel_column;
            row_reg <= pixel_row;
            re_reg <= '0;
            im_reg <= '0;
            count_reg <= '0;
        end
        if (cmd.calc_c) begin
            cre_reg <= mte_pkg::sat_coord(xsum);
            cim_reg <= mte_pkg::sat_coord(ysum);
        end
        if (cmd.mul) begin
            rr_reg <= rr_next;
            ii_reg <= ii_next;
            ri_reg <= ri_next;
        end
        if (cmd.update) begin
            re_reg <= mte_pkg::sat_coord(nr);
            im_reg <= mte_pkg::sat_coord(ni);
            count_reg <= count_reg + mte_pkg::COUNT_W'(1);
        end
        if (cmd.finish) begin
            escape_count_reg <= status.escaped ? count_reg : '0;
            inside_set_reg <= !status.escaped;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            done_reg <= 1'b0;
        end else begin
            done_reg <= cmd.finish;
        end
    end

    assign done = done_reg;
    assign escape_count = escape_count_reg;
    assign inside_set = inside_set_reg;

endmodule

FILE: hw/rtl/mandelbrot_escape_time.sv
// Top level of the Mandelbrot escape-time evaluator.
//
//  channel   direction  handshake               payload
//  -------   ---------  ---------------------   ---------------------------------
//  command   in         start && !busy          pixel_column, pixel_row
//  result    out        done (one cycle)        escape_count, inside_set
//  config    in         cfg_valid && cfg_ready  cfg_index, cfg_data
//
// A pixel keeps busy high from its accepting edge through N + 1 escape tests, where N is
// the number of z updates (at most iteration_limit): the pixel is first mapped to c,
// then each escape test passes through the three multipliers and then through the add,
// clamp and escape test. done follows in the next cycle, and a new pixel is taken in
// the cycle done is shown. Reset restores the register defaults. Results cannot be
// stalled; cfg_ready is always high.
module mandelbrot_escape_time #(
    parameter int MAX_COLUMNS = mte_pkg::DEFAULT_MAX_COLUMNS,
    parameter int MAX_ROWS = mte_pkg::DEFAULT_MAX_ROWS,
    parameter int FRACTION_BITS = mte_pkg::DEFAULT_FRACTION_BITS,
    localparam int COL_W = $clog2(MAX_COLUMNS),
    localparam int ROW_W = $clog2(MAX_ROWS)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [COL_W-1:0]               pixel_column,
    input  logic [ROW_W-1:0]               pixel_row,
    output logic                           done,
    output logic [mte_pkg::COUNT_W-1:0]    escape_count,
    output logic                           inside_set,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [mte_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mte_pkg::CFG_DATA_W-1:0] cfg_data
);

    mte_pkg::mte_cmd_t cmd;
    mte_pkg::mte_status_t status;

    assign cfg_ready = 1'b1;

    mte_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    mte_datapath #(
        .MAX_COLUMNS   (MAX_COLUMNS),
        .MAX_ROWS      (MAX_ROWS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pixel_column (pixel_column),
        .pixel_row    (pixel_row),
        .cmd          (cmd),
        .status       (status),
        .done         (done),
        .escape_count (escape_count),
        .inside_set   (inside_set)
    );

endmodule

FILE: hw/rtl/mte_checker.sv
// Port-level checks for the escape-time evaluator, bound to the top level.
module mte_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        done,
    input logic [mte_pkg::COUNT_W-1:0] escape_count,
    input logic                        inside_set
);

    // An accepted transaction keeps the block busy in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    // A result is only shown once the block has gone idle.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result strobe while busy");

    // Two results can never come in consecutive cycles.
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("result strobe held for more than one cycle");

    // Inside points report a zero count; escaped points took at least one update.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((inside_set && escape_count == '0) || (!inside_set && escape_count != '0)))
        else $error("escape count does not match inside flag");

endmodule

bind mandelbrot_escape_time mte_checker u_mte_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .escape_count (escape_count),
    .inside_set   (inside_set)
);
